/* hdl/ecam_pkg.sv */
`default_nettype none
package ecam_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int DIR_FRAC_BITS   = 14;
  localparam int CORDIC_STEPS    = 16;

  localparam int ATAN_LEN = 24;
  localparam int NSTEPS   = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int STEP_W   = 5;

  localparam int FULL    = 360 << ANGLE_FRAC_BITS;
  localparam int HALF    = 180 << ANGLE_FRAC_BITS;
  localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
  localparam int ZFRAC   = 16;
  localparam int ZSHIFT  = ZFRAC - ANGLE_FRAC_BITS;

  localparam int AW  = 17;          // stored angle
  localparam int TW  = 19;          // angle sums
  localparam int RW  = 19;          // angle reduction
  localparam int ZW  = 25;          // cordic residual angle
  localparam int XW  = 34;          // cordic x and y
  localparam int PW  = 70;          // full direction products
  localparam int LOW = 17;          // low slice of a split operand
  localparam int MAW = LOW + 1;
  localparam int MBW = XW + 1;
  localparam int MPW = MAW + MBW;

  localparam int IN_W  = 176;
  localparam int OUT_W = 200;

  localparam int DIR_HI = ((1 << DIR_FRAC_BITS) > 32767) ? 32767 : (1 << DIR_FRAC_BITS);
  localparam int DIR_LO = -(1 << DIR_FRAC_BITS);
  localparam int PROD_SHIFT = 60 - DIR_FRAC_BITS;
  localparam int SIN_SHIFT  = 30 - DIR_FRAC_BITS;

  localparam logic signed [XW-1:0] KGAIN = XW'(652032874);

  typedef enum logic [2:0] {
    ACT_ROTATE      = 3'd0,
    ACT_MOVE        = 3'd1,
    ACT_SET_POS     = 3'd2,
    ACT_SET_ROLL    = 3'd3,
    ACT_SET_PITCH   = 3'd4,
    ACT_SET_HEADING = 3'd5
  } ecam_action_t;

  typedef struct packed {
    logic                 done;
    logic signed [XW-1:0] sin_v;
    logic signed [XW-1:0] cos_v;
  } ecam_trig_t;

  // arctangent of 2^-i in degrees times 2^16
  function automatic logic signed [ZW-1:0] atan_deg(input logic [STEP_W-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = ZW'(2949120);
      5'd1:  v = ZW'(1740967);
      5'd2:  v = ZW'(919879);
      5'd3:  v = ZW'(466945);
      5'd4:  v = ZW'(234379);
      5'd5:  v = ZW'(117304);
      5'd6:  v = ZW'(58666);
      5'd7:  v = ZW'(29335);
      5'd8:  v = ZW'(14668);
      5'd9:  v = ZW'(7334);
      5'd10: v = ZW'(3667);
      5'd11: v = ZW'(1833);
      5'd12: v = ZW'(917);
      5'd13: v = ZW'(458);
      5'd14: v = ZW'(229);
      5'd15: v = ZW'(115);
      5'd16: v = ZW'(57);
      5'd17: v = ZW'(29);
      5'd18: v = ZW'(14);
      5'd19: v = ZW'(7);
      5'd20: v = ZW'(4);
      5'd21: v = ZW'(2);
      5'd22: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // round half up by sh bits, then clamp to the direction range
  function automatic logic signed [15:0] rnd_clamp(input logic signed [PW-1:0] v,
                                                    input int sh);
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] t;
    logic signed [15:0]   r;
    rnd = PW'(1) << (sh - 1);
    t = (v + rnd) >>> sh;
    if (t > DIR_HI) r = 16'(DIR_HI);
    else if (t < DIR_LO) r = 16'(DIR_LO);
    else r = 16'(t);
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/euler_camera_orientation.sv */
// camera orientation engine: roll, pitch and heading angles, a unit view
// direction and an eye position, updated by one action word at a time.
// input channel: in_tuser carries the action, in_tdata the deltas, the
// absolute angle, the move speed and the new position. output channel: one
// word per action reporting the full state after it.
// rotate and the three set actions run the sine/cosine engine twice (pitch
// then heading), each pass a start, an angle reduction, the cordic steps and
// a hand-over, then the split products on the shared multiplier and the
// output load. move runs its three products on the shared multiplier, then
// loads the output; set_position and unused codes load the output directly.
// in_tready is high only while the sequencer is idle, so one action is in
// flight at a time; the sine/cosine loop and the shared multiplier set
// the rate.
// the result sits in an output register; the next action is taken while it
// waits, and that action holds in its final state until the word is taken.
// reset: angles zero, direction unit z, eye at the origin, no word pending.
`default_nettype none
module euler_camera_orientation import ecam_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // delta_roll, delta_pitch, delta_heading, angle_value, speed, pos_x, pos_y, pos_z
  input  logic [IN_W-1:0]  in_tdata,
  // action
  input  logic [2:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // out_dir_x, out_dir_y, out_dir_z, out_eye_x, out_eye_y, out_eye_z,
  // out_roll, out_pitch, out_heading, zero fill
  output logic [OUT_W-1:0] out_tdata
);

  typedef enum logic [2:0] {S_IDLE, S_TRIG, S_MUL, S_MOVE, S_FIN} state_t;

  state_t                state_r;
  logic signed [AW-1:0]  roll_r;
  logic signed [AW-1:0]  pitch_r;
  logic signed [AW-1:0]  heading_r;
  logic signed [15:0]    dirx_r;
  logic signed [15:0]    diry_r;
  logic signed [15:0]    dirz_r;
  logic signed [31:0]    eyex_r;
  logic signed [31:0]    eyey_r;
  logic signed [31:0]    eyez_r;
  logic signed [15:0]    speed_r;
  logic signed [XW-1:0]  cp_r;
  logic signed [XW-1:0]  sh_r;
  logic signed [XW-1:0]  ch_r;
  logic                  hsel_r;
  logic                  launched_r;
  logic [2:0]            mc_r;
  logic signed [PW-1:0]  acc_r;
  logic signed [MPW-1:0] prod_r;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r;

  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  full_prod;
  logic                  cstart;
  logic signed [AW-1:0]  cangle;
  ecam_trig_t            trig;

  logic [2:0]            act;
  logic signed [15:0]    d_roll;
  logic signed [15:0]    d_pitch;
  logic signed [15:0]    d_heading;
  logic signed [15:0]    ang_val;
  logic signed [15:0]    spd;

  assign act       = in_tuser;
  assign d_roll    = in_tdata[15:0];
  assign d_pitch   = in_tdata[31:16];
  assign d_heading = in_tdata[47:32];
  assign ang_val   = in_tdata[63:48];
  assign spd       = in_tdata[79:64];

  function automatic logic signed [AW-1:0] wrap_sym(input logic signed [AW-1:0] a,
                                                    input logic signed [15:0] d);
    logic signed [TW-1:0] t;
    t = TW'(a) + TW'(d);
    if (t < -HALF) t = t + TW'(FULL);
    else if (t >= HALF) t = t - TW'(FULL);
    return t[AW-1:0];
  endfunction

  function automatic logic signed [AW-1:0] wrap_pos(input logic signed [AW-1:0] a,
                                                    input logic signed [15:0] d);
    logic signed [TW-1:0] t;
    t = TW'(a) + TW'(d);
    if (t < 0) t = t + TW'(FULL);
    else if (t >= FULL) t = t - TW'(FULL);
    return t[AW-1:0];
  endfunction

  function automatic logic signed [31:0] move_axis(input logic signed [31:0] e,
                                                   input logic signed [MPW-1:0] p);
    logic signed [MPW-1:0] rnd;
    logic signed [MPW-1:0] rs;
    logic signed [MPW:0]   s;
    logic signed [31:0]    r;
    rnd = MPW'(1) << (DIR_FRAC_BITS - 1);
    rs  = (p + rnd) >>> DIR_FRAC_BITS;
    s   = (MPW + 1)'(e) + (MPW + 1)'(rs);
    if (s[MPW:31] != {(MPW - 30){s[MPW]}}) r = s[MPW] ? 32'h8000_0000 : 32'h7fff_ffff;
    else r = s[31:0];
    return r;
  endfunction

  assign cstart = (state_r == S_TRIG) && !launched_r;
  assign cangle = hsel_r ? heading_r : pitch_r;

  ecam_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cstart),
    .angle (cangle),
    .trig  (trig)
  );

  // shared multiplier: split heading terms times cos pitch, or direction times speed
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL: begin
        mul_b = MBW'(cp_r);
        case (mc_r)
          3'd0:    mul_a = $signed({1'b0, sh_r[LOW-1:0]});
          3'd1:    mul_a = MAW'($signed(sh_r[XW-1:LOW]));
          3'd2:    mul_a = $signed({1'b0, ch_r[LOW-1:0]});
          default: mul_a = MAW'($signed(ch_r[XW-1:LOW]));
        endcase
      end
      S_MOVE: begin
        mul_b = MBW'(speed_r);
        case (mc_r)
          3'd0:    mul_a = MAW'(dirx_r);
          3'd1:    mul_a = MAW'(diry_r);
          default: mul_a = MAW'(dirz_r);
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    full_prod = acc_r + (PW'(prod_r) <<< LOW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hsel_r      <= 1'b0;
      launched_r  <= 1'b0;
      mc_r        <= '0;
      roll_r      <= '0;
      pitch_r     <= '0;
      heading_r   <= '0;
      dirx_r      <= '0;
      diry_r      <= '0;
      dirz_r      <= 16'(DIR_HI);
      eyex_r      <= '0;
      eyey_r      <= '0;
      eyez_r      <= '0;
    end else begin
      prod_r <= mul_a * mul_b;
      if (out_tready && state_r != S_FIN) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            hsel_r     <= 1'b0;
            launched_r <= 1'b0;
            mc_r       <= '0;
            state_r    <= S_TRIG;
            case (act)
              ACT_ROTATE: begin
                roll_r    <= wrap_sym(roll_r, d_roll);
                pitch_r   <= wrap_sym(pitch_r, d_pitch);
                heading_r <= wrap_pos(heading_r, d_heading);
              end
              ACT_MOVE: begin
                speed_r <= spd;
                state_r <= S_MOVE;
              end
              ACT_SET_POS: begin
                eyex_r  <= in_tdata[111:80];
                eyey_r  <= in_tdata[143:112];
                eyez_r  <= in_tdata[175:144];
                state_r <= S_FIN;
              end
              ACT_SET_ROLL:    roll_r    <= AW'(ang_val);
              ACT_SET_PITCH:   pitch_r   <= AW'(ang_val);
              ACT_SET_HEADING: heading_r <= AW'(ang_val);
              default:         state_r   <= S_FIN;
            endcase
          end
        end
        S_TRIG: begin
          launched_r <= 1'b1;
          if (trig.done) begin
            launched_r <= 1'b0;
            if (!hsel_r) begin
              cp_r   <= trig.cos_v;
              diry_r <= rnd_clamp(PW'($signed(trig.sin_v)), SIN_SHIFT);
              hsel_r <= 1'b1;
            end else begin
              sh_r    <= trig.sin_v;
              ch_r    <= trig.cos_v;
              mc_r    <= '0;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          mc_r <= mc_r + 1'b1;
          case (mc_r)
            3'd1: acc_r <= PW'(prod_r);
            3'd2: dirx_r <= rnd_clamp(full_prod, PROD_SHIFT);
            3'd3: acc_r <= PW'(prod_r);
            3'd4: begin
              dirz_r  <= rnd_clamp(-full_prod, PROD_SHIFT);
              state_r <= S_FIN;
            end
            default: ;
          endcase
        end
        S_MOVE: begin
          mc_r <= mc_r + 1'b1;
          case (mc_r)
            3'd1: eyex_r <= move_axis(eyex_r, prod_r);
            3'd2: eyey_r <= move_axis(eyey_r, prod_r);
            3'd3: begin
              eyez_r  <= move_axis(eyez_r, prod_r);
              state_r <= S_FIN;
            end
            default: ;
          endcase
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {5'b0, heading_r, pitch_r, roll_r, eyez_r, eyey_r, eyex_r,
                            dirz_r, diry_r, dirx_r};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  ast_trig_owner: assert property (@(posedge clk) disable iff (!rst_n)
    trig.done |-> state_r == S_TRIG)
    else $error("sine/cosine result outside the trig phase");

  ast_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    dirx_r >= DIR_LO && dirx_r <= DIR_HI && diry_r >= DIR_LO && diry_r <= DIR_HI &&
    dirz_r >= DIR_LO && dirz_r <= DIR_HI)
    else $error("direction component out of range");

  ast_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while an action is in flight");
`endif

endmodule
`default_nettype wire

/* hdl/ecam_cordic.sv */
`default_nettype none
module ecam_cordic import ecam_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [AW-1:0] angle,
  output ecam_trig_t           trig
);

  typedef enum logic [1:0] {C_IDLE, C_RED, C_ROT} cstate_t;

  localparam logic signed [RW-1:0] FULL_R    = RW'(FULL);
  localparam logic signed [RW-1:0] HALF_R    = RW'(HALF);
  localparam logic signed [RW-1:0] QUARTER_R = RW'(QUARTER);

  cstate_t              state_r;
  logic signed [RW-1:0] r_r;
  logic signed [RW-1:0] r2;
  logic signed [RW-1:0] r3;
  logic                 negc;
  logic                 negc_r;
  logic signed [ZW-1:0] z0;
  logic signed [ZW-1:0] z_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic [STEP_W-1:0]    i_r;
  logic                 done_r;

  // fold the reduced angle into [-90,90] degrees
  always_comb begin
    r2   = (r_r >= HALF_R) ? r_r - FULL_R : r_r;
    r3   = r2;
    negc = 1'b0;
    if (r2 > QUARTER_R) begin
      r3   = HALF_R - r2;
      negc = 1'b1;
    end else if (r2 < -QUARTER_R) begin
      r3   = -HALF_R - r2;
      negc = 1'b1;
    end
    z0 = ZW'(r3) <<< ZSHIFT;
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        C_IDLE: begin
          if (start) begin
            r_r     <= RW'(angle);
            state_r <= C_RED;
          end
        end
        C_RED: begin
          if (r_r < 0) begin
            r_r <= r_r + FULL_R;
          end else if (r_r >= FULL_R) begin
            r_r <= r_r - FULL_R;
          end else begin
            z_r     <= z0;
            negc_r  <= negc;
            x_r     <= KGAIN;
            y_r     <= '0;
            i_r     <= '0;
            state_r <= C_ROT;
          end
        end
        C_ROT: begin
          if (z_r >= 0) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - atan_deg(i_r);
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + atan_deg(i_r);
          end
          i_r <= i_r + 1'b1;
          if (i_r == STEP_W'(NSTEPS - 1)) begin
            done_r  <= 1'b1;
            state_r <= C_IDLE;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign trig.done  = done_r;
  assign trig.sin_v = y_r;
  assign trig.cos_v = negc_r ? -x_r : x_r;

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
module testbench;
  import ecam_pkg::*;

  localparam int SEQ_LIMIT = 20000;

  typedef struct {
    logic [2:0]         act;
    logic signed [15:0] d_roll, d_pitch, d_head, ang, spd;
    logic signed [31:0] px, py, pz;
  } cam_cmd_t;

  typedef struct {
    logic signed [15:0] dx, dy, dz;
    logic signed [31:0] ex, ey, ez;
    logic signed [16:0] roll, pitch, head;
  } cam_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  cam_cmd_t   pending_cmds[$];
  cam_state_t expected_states[$];
  cam_state_t cam;
  bit         failed = 1'b0;
  bit         hold_sender = 1'b0;
  bit         no_idle = 1'b0;
  bit         stim_done = 1'b0;
  bit         in_fired = 1'b0;
  int         stall_pct = 34;
  int         quiet_cycles = 0;

  always #10 clk = ~clk;

  euler_camera_orientation DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_up(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_unit(longint v);
    longint hi;
    hi = ((1 << DIR_FRAC_BITS) > 32767) ? 32767 : (1 << DIR_FRAC_BITS);
    if (v > hi) return hi;
    if (v < -(longint'(1) << DIR_FRAC_BITS)) return -(longint'(1) << DIR_FRAC_BITS);
    return v;
  endfunction

  // sine and cosine in Q30, angle in degrees times 64
  task automatic trig_q30(input longint a, output longint s, output longint c);
    longint full_a, half_a, quart_a, r, x, y, z, xs, ys;
    longint atan_tbl[24];
    bit negc;
    int n;
    atan_tbl = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
    full_a = 360 << ANGLE_FRAC_BITS;
    half_a = 180 << ANGLE_FRAC_BITS;
    quart_a = 90 << ANGLE_FRAC_BITS;
    negc = 1'b0;
    x = 652032874;
    y = 0;
    n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    r = a % full_a;
    if (r < 0) r += full_a;
    if (r >= half_a) r -= full_a;
    if (r > quart_a) begin
      r = half_a - r;
      negc = 1'b1;
    end else if (r < -quart_a) begin
      r = -half_a - r;
      negc = 1'b1;
    end
    z = r * (longint'(1) << (16 - ANGLE_FRAC_BITS));
    for (int i = 0; i < n; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_tbl[i];
      end else begin
        x += ys; y -= xs; z += atan_tbl[i];
      end
    end
    s = y;
    c = negc ? -x : x;
  endtask

  task automatic refresh_direction();
    longint sh, ch, sp, cp;
    trig_q30(longint'(cam.head), sh, ch);
    trig_q30(longint'(cam.pitch), sp, cp);
    cam.dx = 16'(clamp_unit(rnd_up(sh * cp, 60 - DIR_FRAC_BITS)));
    cam.dy = 16'(clamp_unit(rnd_up(sp, 30 - DIR_FRAC_BITS)));
    cam.dz = 16'(clamp_unit(rnd_up(-(ch * cp), 60 - DIR_FRAC_BITS)));
  endtask

  function automatic logic signed [31:0] step_axis(logic signed [31:0] e,
                                                   logic signed [15:0] d,
                                                   logic signed [15:0] sp);
    longint v;
    v = longint'(e) + rnd_up(longint'(d) * longint'(sp), DIR_FRAC_BITS);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return 32'(v);
  endfunction

  function automatic logic signed [16:0] wrap_sum(longint t, longint lo, longint span);
    if (t < lo) t += span;
    else if (t >= lo + span) t -= span;
    return 17'(t);
  endfunction

  task automatic apply_action(input cam_cmd_t c);
    longint span;
    span = 360 << ANGLE_FRAC_BITS;
    case (c.act)
      ACT_ROTATE: begin
        cam.roll  = wrap_sum(longint'(cam.roll) + c.d_roll, -(span / 2), span);
        cam.pitch = wrap_sum(longint'(cam.pitch) + c.d_pitch, -(span / 2), span);
        cam.head  = wrap_sum(longint'(cam.head) + c.d_head, 0, span);
        refresh_direction();
      end
      ACT_MOVE: begin
        cam.ex = step_axis(cam.ex, cam.dx, c.spd);
        cam.ey = step_axis(cam.ey, cam.dy, c.spd);
        cam.ez = step_axis(cam.ez, cam.dz, c.spd);
      end
      ACT_SET_POS: begin
        cam.ex = c.px; cam.ey = c.py; cam.ez = c.pz;
      end
      ACT_SET_ROLL: begin
        cam.roll = 17'(c.ang); refresh_direction();
      end
      ACT_SET_PITCH: begin
        cam.pitch = 17'(c.ang); refresh_direction();
      end
      ACT_SET_HEADING: begin
        cam.head = 17'(c.ang); refresh_direction();
      end
      default: ;
    endcase
    expected_states.push_back(cam);
  endtask

  function automatic logic signed [15:0] rand_delta();
    case ($urandom_range(0, 5))
      0: return 16'sd23039;
      1: return -16'sd23039;
      2: return 16'($urandom_range(0, 46078)) - 16'sd23039;
      default: return 16'($urandom_range(0, 2 * 5760)) - 16'sd5760;
    endcase
  endfunction

  function automatic cam_cmd_t rand_cmd();
    cam_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c.act = (pick < 30) ? ACT_ROTATE : (pick < 55) ? ACT_MOVE :
            (pick < 65) ? ACT_SET_POS : (pick < 74) ? ACT_SET_ROLL :
            (pick < 84) ? ACT_SET_PITCH : (pick < 94) ? ACT_SET_HEADING :
            3'($urandom_range(6, 7));
    c.d_roll = rand_delta();
    c.d_pitch = rand_delta();
    c.d_head = rand_delta();
    c.ang = 16'($urandom_range(0, 46079)) - 16'sd23040;
    c.spd = 16'($urandom);
    c.px = ($urandom_range(0, 3) == 0) ? 32'($urandom) :
           32'($urandom_range(0, 2000000)) - 1000000;
    c.py = ($urandom_range(0, 3) == 0) ? 32'($urandom) :
           32'($urandom_range(0, 2000000)) - 1000000;
    c.pz = ($urandom_range(0, 3) == 0) ? 32'($urandom) :
           32'($urandom_range(0, 2000000)) - 1000000;
    return c;
  endfunction

  function automatic cam_cmd_t make_cmd(logic [2:0] act, logic signed [15:0] dr,
                                        logic signed [15:0] dp, logic signed [15:0] dh,
                                        logic signed [15:0] ang, logic signed [15:0] spd,
                                        logic signed [31:0] p);
    cam_cmd_t c;
    c.act = act; c.d_roll = dr; c.d_pitch = dp; c.d_head = dh;
    c.ang = ang; c.spd = spd; c.px = p; c.py = -p; c.pz = p;
    return c;
  endfunction

  // driver
  always @(negedge clk) begin
    cam_cmd_t c;
    bit send;
    if (rst_n) begin
      send = (in_fired || !in_tvalid) && pending_cmds.size() > 0 && !hold_sender &&
             (no_idle || $urandom_range(0, 99) >= stall_pct);
      if (send) begin
        c = pending_cmds.pop_front();
        in_tdata <= {c.pz, c.py, c.px, c.spd, c.ang, c.d_head, c.d_pitch, c.d_roll};
        in_tuser <= c.act;
        in_tvalid <= 1'b1;
        apply_action(c);
      end else if (in_fired) begin
        in_tvalid <= 1'b0;
      end
      out_tready <= no_idle || ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    cam_state_t got, want;
    in_fired <= in_tvalid && in_tready;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > SEQ_LIMIT) begin
        $display("%0t: timeout, %0d words outstanding", $time, expected_states.size());
        $display("Test completed with failures");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        {got.head, got.pitch, got.roll, got.ez, got.ey, got.ex, got.dz, got.dy, got.dx} =
          out_tdata[OUT_W-6:0];
        if (expected_states.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_tdata);
          failed = 1'b1;
        end else begin
          want = expected_states.pop_front();
          if (got.dx !== want.dx) begin
            $display("%0t: dir_x exp %0d got %0d", $time, want.dx, got.dx); failed = 1'b1;
          end
          if (got.dy !== want.dy) begin
            $display("%0t: dir_y exp %0d got %0d", $time, want.dy, got.dy); failed = 1'b1;
          end
          if (got.dz !== want.dz) begin
            $display("%0t: dir_z exp %0d got %0d", $time, want.dz, got.dz); failed = 1'b1;
          end
          if (got.ex !== want.ex) begin
            $display("%0t: eye_x exp %0d got %0d", $time, want.ex, got.ex); failed = 1'b1;
          end
          if (got.ey !== want.ey) begin
            $display("%0t: eye_y exp %0d got %0d", $time, want.ey, got.ey); failed = 1'b1;
          end
          if (got.ez !== want.ez) begin
            $display("%0t: eye_z exp %0d got %0d", $time, want.ez, got.ez); failed = 1'b1;
          end
          if (got.roll !== want.roll) begin
            $display("%0t: roll exp %0d got %0d", $time, want.roll, got.roll);
            failed = 1'b1;
          end
          if (got.pitch !== want.pitch) begin
            $display("%0t: pitch exp %0d got %0d", $time, want.pitch, got.pitch);
            failed = 1'b1;
          end
          if (got.head !== want.head) begin
            $display("%0t: heading exp %0d got %0d", $time, want.head, got.head);
            failed = 1'b1;
          end
        end
      end
    end
  end

  initial begin
    cam.roll = '0; cam.pitch = '0; cam.head = '0;
    cam.dx = '0; cam.dy = '0; cam.dz = 16'(1 << DIR_FRAC_BITS);
    cam.ex = '0; cam.ey = '0; cam.ez = '0;
    // directed: extremes, every action, wraps, unused codes, saturation
    pending_cmds.push_back(make_cmd(ACT_MOVE, 0, 0, 0, 0, 16'sh7fff, 0));
    pending_cmds.push_back(make_cmd(ACT_ROTATE, 23039, 23039, 23039, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_ROTATE, 23039, 23039, 23039, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_ROTATE, -23039, -23039, -23039, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_ROTATE, -23039, -23039, -23039, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_ROTATE, -23039, -23039, -23039, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_SET_ROLL, 0, 0, 0, -16'sd23040, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_SET_PITCH, 0, 0, 0, 16'sd5760, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_SET_PITCH, 0, 0, 0, -16'sd23040, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_SET_HEADING, 0, 0, 0, 16'sd23039, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_SET_HEADING, 0, 0, 0, -16'sd5760, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_ROTATE, 0, 0, -23039, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_SET_POS, 0, 0, 0, 0, 0, 32'sh7fffff00));
    pending_cmds.push_back(make_cmd(ACT_MOVE, 0, 0, 0, 0, 16'sh7fff, 0));
    pending_cmds.push_back(make_cmd(ACT_MOVE, 0, 0, 0, 0, 16'sh8000, 0));
    pending_cmds.push_back(make_cmd(ACT_SET_POS, 0, 0, 0, 0, 0, 32'sh80000000));
    pending_cmds.push_back(make_cmd(ACT_MOVE, 0, 0, 0, 0, 16'sh8000, 0));
    pending_cmds.push_back(make_cmd(3'd6, 16'shffff, 16'shffff, 16'shffff, 16'shffff,
                                    16'shffff, -1));
    pending_cmds.push_back(make_cmd(3'd7, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_SET_POS, 0, 0, 0, 0, 0, -1));
    pending_cmds.push_back(make_cmd(ACT_MOVE, 0, 0, 0, 0, 16'sd1, 0));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (150) pending_cmds.push_back(rand_cmd());
    wait (pending_cmds.size() == 0 && expected_states.size() == 0);
    // sender pauses until all words are back, then a stretch with no idling
    @(negedge clk);
    hold_sender = 1'b1;
    repeat (100) pending_cmds.push_back(rand_cmd());
    repeat (60) @(posedge clk);
    hold_sender = 1'b0;
    no_idle = 1'b1;
    wait (pending_cmds.size() == 0);
    no_idle = 1'b0;
    repeat (200) pending_cmds.push_back(rand_cmd());
    wait (pending_cmds.size() == 0 && expected_states.size() == 0);
    repeat (100) @(posedge clk);
    if (!failed && expected_states.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
